FILE: rtl/qct_pkg.sv
`timescale 1ns / 1ps

package qct_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int ID_W     = 5;
    localparam int TS_W     = 64;
    localparam int STATUS_W = 2;
    localparam int GEN_W    = 64;
    localparam int AST_W    = 2;
    localparam int MINI_W   = 25;
    localparam int PHASE_W  = 2;

    localparam int DEF_NUM_CPUS = 32;
    localparam logic [MINI_W-1:0] MIN_INTERVAL_RST = MINI_W'(96000);

    // Event kinds
    localparam logic [CMD_W-1:0] CMD_JOIN     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LEAVE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHECKIN  = 2'd3;

    // Per-processor phase
    localparam logic [PHASE_W-1:0] PH_NONE    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PENDING = 2'd1;
    localparam logic [PHASE_W-1:0] PH_JOINED  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_LEFT    = 2'd3;

    // Result status
    localparam logic [STATUS_W-1:0] ST_APPLIED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;

    // Callback request
    localparam logic [AST_W-1:0] AST_NONE   = 2'd0;
    localparam logic [AST_W-1:0] AST_ARM    = 2'd1;
    localparam logic [AST_W-1:0] AST_DISARM = 2'd2;

    // What the state store shows for the addressed processor
    typedef struct packed {
        logic               in_range;
        logic [PHASE_W-1:0] phase;
        logic               bit_exp;
        logic               bit_chk;
        logic               empty;     // both masks all zero
        logic               done;      // expected == checked-in
        logic               done_wo;   // equal outside this processor's bit
    } qct_view_t;

    // State updates decided for one event
    typedef struct packed {
        logic               ph_we;
        logic [PHASE_W-1:0] ph_val;
        logic               time_we;
        logic               exp_set;
        logic               exp_clr;
        logic               chk_set;
        logic               chk_clr;
        logic               commit;
    } qct_upd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                committed;
        logic [AST_W-1:0]    ast;
    } qct_res_t;

endpackage

FILE: rtl/qct_if.sv
`timescale 1ns / 1ps

// Event channel
interface qct_req_if;
    import qct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   cpu_id;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, cmd, cpu_id, timestamp, input ready);
    modport sink   (input valid, cmd, cpu_id, timestamp, output ready);
endinterface

// Result channel
interface qct_rsp_if;
    import qct_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                committed;
    logic [GEN_W-1:0]    generation;
    logic [AST_W-1:0]    ast_request;

    modport source (output valid, status, committed, generation, ast_request, input ready);
    modport sink   (input valid, status, committed, generation, ast_request, output ready);
endinterface

FILE: rtl/quiescent_checkin_tracker_unit.sv
`timescale 1ns / 1ps

// Channel | Dir | Fields
// --------+-----+------------------------------------------------
// req     | in  | cmd[1:0], cpu_id[4:0], timestamp[63:0]
// rsp     | out | status[1:0], committed, generation[63:0], ast_request[1:0]
// cfg     | in  | cfg_wr_en, cfg_wr_data[24:0] (min_interval)
//
// One word per cycle sustained while the result side does not stall: a word is
// registered in the input stage, then evaluated, and the state is updated as the
// result register is loaded. The result is registered behind the input register.
// Reset (rst_n, asynchronous) clears all tracker state; min_interval returns to 96000.
// A stalled result holds the evaluation stage; req.ready stays high while
// the result register can drain or is empty.
module quiescent_checkin_tracker_unit #(
    parameter int NUM_CPUS = qct_pkg::DEF_NUM_CPUS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    qct_req_if.sink                        req,
    qct_rsp_if.source                      rsp,
    input  logic                           cfg_wr_en,
    input  logic [qct_pkg::MINI_W-1:0]     cfg_wr_data
);
    import qct_pkg::*;

    logic                in_valid_reg;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [ID_W-1:0]     in_id_reg;
    logic [TS_W-1:0]     in_ts_reg;
    logic [MINI_W-1:0]   min_interval_reg;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_committed_reg;
    logic [GEN_W-1:0]    out_gen_reg;
    logic [AST_W-1:0]    out_ast_reg;

    logic                advance;
    logic                proc;
    qct_view_t           view;
    qct_upd_t            upd;
    qct_res_t            res;
    logic [TS_W-1:0]     last_time;
    logic [GEN_W-1:0]    gen_cur;
    logic [GEN_W-1:0]    gen_after;

    // Handshake
    assign advance   = !out_valid_reg || rsp.ready;
    assign proc      = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign out_valid_next = proc ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_interval_reg <= MIN_INTERVAL_RST;
        else if (cfg_wr_en)
            min_interval_reg <= cfg_wr_data;
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_cmd_reg <= req.cmd;
            in_id_reg  <= req.cpu_id;
            in_ts_reg  <= req.timestamp;
        end
    end

    qct_state #(
        .NUM_CPUS (NUM_CPUS)
    ) u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .apply     (proc),
        .cpu_id    (in_id_reg),
        .timestamp (in_ts_reg),
        .upd       (upd),
        .view      (view),
        .last_time (last_time),
        .gen_cur   (gen_cur),
        .gen_after (gen_after)
    );

    qct_eval u_eval (
        .cmd          (in_cmd_reg),
        .timestamp    (in_ts_reg),
        .min_interval (min_interval_reg),
        .last_time    (last_time),
        .view         (view),
        .res          (res),
        .upd          (upd)
    );

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            out_status_reg    <= res.status;
            out_committed_reg <= res.committed;
            out_gen_reg       <= gen_after;
            out_ast_reg       <= res.ast;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.committed   = out_committed_reg;
    assign rsp.generation  = out_gen_reg;
    assign rsp.ast_request = out_ast_reg;

`ifndef SYNTHESIS
    // Generation moves by one exactly on an evaluated commit
    a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
        proc && upd.commit |=> gen_cur == $past(gen_cur) + 64'd1)
        else $error("generation did not advance on commit");

    a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(proc && upd.commit) |=> $stable(gen_cur))
        else $error("generation changed without commit");

    // A fresh result always comes from a held input word
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared with no word in the input stage");

    // Errors and skips never commit
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_APPLIED |-> !out_committed_reg)
        else $error("commit reported on a non-applied event");

    // Input stage holds while the result side is stalled
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_ts_reg) && $stable(in_id_reg))
        else $error("input stage lost a stalled word");
`endif

endmodule

FILE: rtl/qct_eval.sv
`timescale 1ns / 1ps

// Decision logic for one event: result fields and the state updates it causes
module qct_eval (
    input  logic [qct_pkg::CMD_W-1:0]  cmd,
    input  logic [qct_pkg::TS_W-1:0]   timestamp,
    input  logic [qct_pkg::MINI_W-1:0] min_interval,
    input  logic [qct_pkg::TS_W-1:0]   last_time,
    input  qct_pkg::qct_view_t         view,
    output qct_pkg::qct_res_t          res,
    output qct_pkg::qct_upd_t          upd
);
    import qct_pkg::*;

    logic [TS_W-1:0] elapsed;
    logic            too_soon;
    logic            mine;

    // Wrapping interval test
    assign elapsed  = timestamp - last_time;
    assign too_soon = elapsed <= {{(TS_W-MINI_W){1'b0}}, min_interval};
    assign mine     = view.bit_exp | view.bit_chk;

    always_comb
    begin
        res = '{status: ST_APPLIED, committed: 1'b0, ast: AST_NONE};
        upd = '0;
        if (!view.in_range)
        begin
            res.status = ST_ERROR;
        end
        else
        begin
            case (cmd)
                CMD_JOIN:
                begin
                    if ((view.phase != PH_NONE && view.phase != PH_LEFT) || mine)
                    begin
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        upd.ph_we  = 1'b1;
                        upd.ph_val = PH_PENDING;
                        res.ast    = AST_ARM;
                    end
                end
                CMD_ACTIVATE:
                begin
                    if (view.phase != PH_PENDING || mine)
                    begin
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        upd.ph_we   = 1'b1;
                        upd.ph_val  = PH_JOINED;
                        upd.time_we = 1'b1;
                        upd.exp_set = 1'b1;
                        // first member of an empty round only expects
                        upd.chk_set = !view.empty;
                    end
                end
                CMD_LEAVE:
                begin
                    if (view.phase == PH_PENDING)
                    begin
                        upd.ph_we  = 1'b1;
                        upd.ph_val = PH_LEFT;
                        res.ast    = AST_DISARM;
                    end
                    else if (view.phase != PH_JOINED || !view.bit_exp)
                    begin
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        upd.ph_we     = 1'b1;
                        upd.ph_val    = PH_LEFT;
                        upd.time_we   = 1'b1;
                        upd.exp_clr   = 1'b1;
                        upd.chk_clr   = 1'b1;
                        upd.commit    = !view.done && view.done_wo;
                        res.committed = upd.commit;
                        res.ast       = AST_DISARM;
                    end
                end
                default:
                begin
                    // checkin
                    if (view.phase == PH_NONE)
                    begin
                        res.status = ST_ERROR;
                    end
                    else if (view.phase != PH_JOINED || too_soon)
                    begin
                        res.status = ST_SKIPPED;
                    end
                    else if (!view.bit_exp)
                    begin
                        res.status = ST_ERROR;
                    end
                    else
                    begin
                        upd.time_we = 1'b1;
                        if (view.bit_chk)
                        begin
                            res.status = ST_SKIPPED;
                        end
                        else
                        begin
                            upd.chk_set   = 1'b1;
                            upd.commit    = view.done_wo;
                            res.committed = view.done_wo;
                        end
                    end
                end
            endcase
        end
    end

endmodule

FILE: rtl/qct_state.sv
`timescale 1ns / 1ps

// Per-processor phase and checkin time, round masks and generation counter
module qct_state #(
    parameter int NUM_CPUS = qct_pkg::DEF_NUM_CPUS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        apply,
    input  logic [qct_pkg::ID_W-1:0]    cpu_id,
    input  logic [qct_pkg::TS_W-1:0]    timestamp,
    input  qct_pkg::qct_upd_t           upd,
    output qct_pkg::qct_view_t          view,
    output logic [qct_pkg::TS_W-1:0]    last_time,
    output logic [qct_pkg::GEN_W-1:0]   gen_cur,
    output logic [qct_pkg::GEN_W-1:0]   gen_after
);
    import qct_pkg::*;

    localparam int IDX_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam logic [ID_W:0] NCPU = (ID_W+1)'(NUM_CPUS);

    logic [PHASE_W-1:0]  phase_reg [NUM_CPUS];
    logic [TS_W-1:0]     time_reg  [NUM_CPUS];
    logic [NUM_CPUS-1:0] exp_reg, exp_next;
    logic [NUM_CPUS-1:0] chk_reg, chk_next;
    logic [GEN_W-1:0]    gen_reg;

    logic [IDX_W-1:0]    idx;
    logic [NUM_CPUS-1:0] onehot;
    logic                wr;

    assign idx    = cpu_id[IDX_W-1:0];
    assign onehot = {{(NUM_CPUS-1){1'b0}}, 1'b1} << idx;
    assign wr     = apply && view.in_range;

    // Read side
    always_comb
    begin
        view.in_range = {1'b0, cpu_id} < NCPU;
        view.phase    = phase_reg[idx];
        view.bit_exp  = |(exp_reg & onehot);
        view.bit_chk  = |(chk_reg & onehot);
        view.empty    = (exp_reg == '0) && (chk_reg == '0);
        view.done     = exp_reg == chk_reg;
        view.done_wo  = ((exp_reg ^ chk_reg) & ~onehot) == '0;
    end

    assign last_time = time_reg[idx];
    assign gen_cur   = gen_reg;
    assign gen_after = gen_reg + {{(GEN_W-1){1'b0}}, upd.commit};

    // Mask updates; a commit clears the whole checked-in mask
    always_comb
    begin
        exp_next = exp_reg;
        chk_next = chk_reg;
        if (wr)
        begin
            if (upd.exp_set)
                exp_next = exp_next | onehot;
            if (upd.exp_clr)
                exp_next = exp_next & ~onehot;
            if (upd.chk_set)
                chk_next = chk_next | onehot;
            if (upd.chk_clr)
                chk_next = chk_next & ~onehot;
            if (upd.commit)
                chk_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= '0;
            chk_reg <= '0;
            gen_reg <= '0;
        end
        else
        begin
            exp_reg <= exp_next;
            chk_reg <= chk_next;
            if (wr)
                gen_reg <= gen_after;
        end
    end

    // Per-entry phase and time registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                phase_reg[i] <= PH_NONE;
                time_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                if (wr && upd.ph_we && idx == IDX_W'(i))
                    phase_reg[i] <= upd.ph_val;
                if (wr && upd.time_we && idx == IDX_W'(i))
                    time_reg[i] <= timestamp;
            end
        end
    end

endmodule

FILE: tb/quiescent_checkin_tracker_unit_tb.sv
`timescale 1ns / 1ps

module quiescent_checkin_tracker_unit_tb;
    import qct_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DIR_N      = 24;

    // One result word as the block should give it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                committed;
        logic [GEN_W-1:0]    generation;
        logic [AST_W-1:0]    ast;
    } outcome_t;

    // Directed stimulus row; want is only used when typed is set
    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  id;
        logic [TS_W-1:0]  ts;
        bit               typed;
        outcome_t         want;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [MINI_W-1:0] cfg_wr_data;

    qct_req_if req_ch ();
    qct_rsp_if rsp_ch ();

    quiescent_checkin_tracker_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Mirror of the tracker state
    logic [PHASE_W-1:0] phase_q [32];
    logic [TS_W-1:0]    last_ts [32];
    logic [31:0]        exp_mask;
    logic [31:0]        chk_mask;
    logic [GEN_W-1:0]   gen_cnt;
    logic [MINI_W-1:0]  min_iv;

    outcome_t        pending_results [$];
    int              errors      = 0;
    int              idle_cycles = 0;
    bit              send_calm   = 1'b0;
    bit              recv_calm   = 1'b0;
    logic [TS_W-1:0] now_ts;
    dir_row_t        dir_tab [DIR_N];

    // Clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Work out the result of one event and advance the mirror
    function automatic outcome_t track_event(input logic [CMD_W-1:0] cmd,
                                             input logic [ID_W-1:0]  id,
                                             input logic [TS_W-1:0]  ts);
        outcome_t           o;
        logic [31:0]        b;
        logic [PHASE_W-1:0] ph;
        logic               mine;
        logic               was_done;
        o.status    = ST_APPLIED;
        o.committed = 1'b0;
        o.ast       = AST_NONE;
        b    = 32'd1 << id;
        ph   = phase_q[id];
        mine = |((exp_mask | chk_mask) & b);
        case (cmd)
            CMD_JOIN:
            begin
                if ((ph != PH_NONE && ph != PH_LEFT) || mine)
                    o.status = ST_ERROR;
                else
                begin
                    phase_q[id] = PH_PENDING;
                    o.ast       = AST_ARM;
                end
            end
            CMD_ACTIVATE:
            begin
                if (ph != PH_PENDING || mine)
                    o.status = ST_ERROR;
                else
                begin
                    phase_q[id] = PH_JOINED;
                    last_ts[id] = ts;
                    // first activate into empty masks only marks it expected
                    if (exp_mask != 32'd0 || chk_mask != 32'd0)
                        chk_mask = chk_mask | b;
                    exp_mask = exp_mask | b;
                end
            end
            CMD_LEAVE:
            begin
                if (ph == PH_PENDING)
                begin
                    phase_q[id] = PH_LEFT;
                    o.ast       = AST_DISARM;
                end
                else if (ph != PH_JOINED || (exp_mask & b) == 32'd0)
                    o.status = ST_ERROR;
                else
                begin
                    was_done    = (exp_mask == chk_mask);
                    o.ast       = AST_DISARM;
                    last_ts[id] = ts;
                    exp_mask    = exp_mask & ~b;
                    chk_mask    = chk_mask & ~b;
                    phase_q[id] = PH_LEFT;
                    if (!was_done && exp_mask == chk_mask)
                    begin
                        gen_cnt     = gen_cnt + 1'b1;
                        chk_mask    = 32'd0;
                        o.committed = 1'b1;
                    end
                end
            end
            default:
            begin
                if (ph == PH_NONE)
                    o.status = ST_ERROR;
                else if (ph != PH_JOINED)
                    o.status = ST_SKIPPED;
                else if (ts - last_ts[id] <= TS_W'(min_iv))
                    o.status = ST_SKIPPED;
                else if ((exp_mask & b) == 32'd0)
                    o.status = ST_ERROR;
                else
                begin
                    last_ts[id] = ts;
                    if ((chk_mask & b) != 32'd0)
                        o.status = ST_SKIPPED;
                    else
                    begin
                        chk_mask = chk_mask | b;
                        if (exp_mask == chk_mask)
                        begin
                            gen_cnt     = gen_cnt + 1'b1;
                            chk_mask    = 32'd0;
                            o.committed = 1'b1;
                        end
                    end
                end
            end
        endcase
        o.generation = gen_cnt;
        return o;
    endfunction

    // Offer one event word, wait for it to be taken, then log its expectation
    task automatic send_event(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [TS_W-1:0] ts, input bit typed,
                              input outcome_t want);
        int       gap;
        outcome_t got;
        if ($urandom_range(0, 39) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.cpu_id    <= id;
        req_ch.timestamp <= ts;
        do
            @(posedge clk);
        while (!req_ch.ready);
        got = track_event(cmd, id, ts);
        pending_results.push_back(typed ? want : got);
    endtask

    // Hold the sender until every expected word is back, then a short settle
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_min_interval(input logic [MINI_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        min_iv = v;
    endtask

    // Mostly lawful per-processor sequences over a small pool, with some noise
    task automatic run_traffic(input int n, input logic [TS_W-1:0] start_ts);
        logic [ID_W-1:0]  pool [6];
        logic [ID_W-1:0]  id;
        logic [CMD_W-1:0] cmd;
        logic [TS_W-1:0]  ts;
        int               i;
        int               k;
        int               r;
        now_ts = start_ts;
        k = $urandom_range(1, 6);
        for (i = 0; i < 6; i++)
            pool[i] = ID_W'($urandom_range(0, 31));
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) == 0)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                cmd = CMD_W'($urandom_range(0, 3));
                id  = ID_W'($urandom_range(0, 31));
                ts  = {$urandom, $urandom};
            end
            else
            begin
                // keep every expected processor checking in so rounds close
                if (exp_mask != 32'd0 && $urandom_range(0, 1) == 1)
                begin
                    do
                        id = ID_W'($urandom_range(0, 31));
                    while (!exp_mask[id]);
                end
                else
                    id = pool[$urandom_range(0, k - 1)];
                r = $urandom_range(0, 99);
                case (phase_q[id])
                    PH_PENDING:
                        cmd = (r < 85) ? CMD_ACTIVATE : (r < 95) ? CMD_LEAVE : CMD_CHECKIN;
                    PH_JOINED:
                        cmd = (r < 92) ? CMD_CHECKIN : (r < 96) ? CMD_LEAVE :
                              (r < 98) ? CMD_JOIN : CMD_ACTIVATE;
                    default:
                        cmd = (r < 90) ? CMD_JOIN : CMD_W'($urandom_range(0, 3));
                endcase
                // checkins land on either side of the interval boundary now and then
                r = $urandom_range(0, 99);
                if (cmd == CMD_CHECKIN && r < 20)
                    ts = last_ts[id] + TS_W'(min_iv);
                else if (cmd == CMD_CHECKIN && r < 40)
                    ts = last_ts[id] + TS_W'(min_iv) + 1'b1;
                else
                    ts = now_ts;
                now_ts = now_ts + TS_W'($urandom_range(0, min_iv / 2 + 8));
            end
            send_event(cmd, id, ts, 1'b0, '0);
        end
    endtask

    // Result sink: random stalls, compare each word with the oldest expectation
    initial
    begin : result_sink
        int       gap;
        outcome_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
            if (pending_results.size() == 0)
            begin
                $error("result word with no expectation waiting");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.committed !== want.committed)
                begin
                    $error("committed: expected %0d, got %0d", want.committed,
                           rsp_ch.committed);
                    errors++;
                end
                if (rsp_ch.generation !== want.generation)
                begin
                    $error("generation: expected %0d, got %0d", want.generation,
                           rsp_ch.generation);
                    errors++;
                end
                if (rsp_ch.ast_request !== want.ast)
                begin
                    $error("ast_request: expected %0d, got %0d", want.ast,
                           rsp_ch.ast_request);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("quiescent_checkin_tracker_unit: mismatch");
        $finish;
    end

    // Main sequence
    initial
    begin
        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_JOIN;
        req_ch.cpu_id    <= '0;
        req_ch.timestamp <= '0;
        rsp_ch.ready     <= 1'b0;

        for (int p = 0; p < 32; p++)
        begin
            phase_q[p] = PH_NONE;
            last_ts[p] = '0;
        end
        exp_mask = '0;
        chk_mask = '0;
        gen_cnt  = '0;
        min_iv   = MIN_INTERVAL_RST;

        // directed: errors from idle, join/activate/checkin/leave, interval edges, wrap
        dir_tab = '{
            '{CMD_CHECKIN,  5'd0,  64'd0,      1'b1, '{ST_ERROR,   1'b0, 64'd0, AST_NONE}},
            '{CMD_LEAVE,    5'd31, 64'd0,      1'b1, '{ST_ERROR,   1'b0, 64'd0, AST_NONE}},
            '{CMD_ACTIVATE, 5'd5,  64'd0,      1'b1, '{ST_ERROR,   1'b0, 64'd0, AST_NONE}},
            '{CMD_JOIN,     5'd0,  64'd0,      1'b1, '{ST_APPLIED, 1'b0, 64'd0, AST_ARM}},
            '{CMD_JOIN,     5'd0,  64'd0,      1'b1, '{ST_ERROR,   1'b0, 64'd0, AST_NONE}},
            '{CMD_CHECKIN,  5'd0,  64'd50,     1'b1, '{ST_SKIPPED, 1'b0, 64'd0, AST_NONE}},
            '{CMD_ACTIVATE, 5'd0,  64'd100,    1'b0, '0},
            '{CMD_CHECKIN,  5'd0,  64'd96100,  1'b0, '0},
            '{CMD_CHECKIN,  5'd0,  64'd96101,  1'b0, '0},
            '{CMD_CHECKIN,  5'd0,  64'd96101,  1'b0, '0},
            '{CMD_JOIN,     5'd31, 64'd0,      1'b0, '0},
            '{CMD_ACTIVATE, 5'd31, 64'd200000, 1'b0, '0},
            '{CMD_CHECKIN,  5'd31, '1,         1'b0, '0},
            '{CMD_JOIN,     5'd31, 64'd5,      1'b1, '{ST_ERROR,   1'b0, 64'd1, AST_NONE}},
            '{CMD_ACTIVATE, 5'd31, 64'd5,      1'b1, '{ST_ERROR,   1'b0, 64'd1, AST_NONE}},
            '{CMD_LEAVE,    5'd0,  64'd300000, 1'b0, '0},
            '{CMD_LEAVE,    5'd0,  64'd300001, 1'b1, '{ST_ERROR,   1'b0, 64'd2, AST_NONE}},
            '{CMD_CHECKIN,  5'd0,  64'd0,      1'b0, '0},
            '{CMD_JOIN,     5'd0,  64'd1,      1'b0, '0},
            '{CMD_LEAVE,    5'd0,  64'd2,      1'b0, '0},
            '{CMD_CHECKIN,  5'd31, 64'd0,      1'b0, '0},
            '{CMD_CHECKIN,  5'd31, 64'd96000,  1'b0, '0},
            '{CMD_LEAVE,    5'd31, 64'h5555_5555_5555_5555, 1'b0, '0},
            '{CMD_JOIN,     5'd17, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[j])
            send_event(dir_tab[j].cmd, dir_tab[j].id, dir_tab[j].ts,
                       dir_tab[j].typed, dir_tab[j].want);
        drain_results();

        // random phases over a spread of intervals, some starting near the wrap
        run_traffic(150, 64'd0);
        set_min_interval('0);
        run_traffic(150, {$urandom, $urandom});
        set_min_interval(MINI_W'(1));
        run_traffic(150, 64'd0);
        set_min_interval('1);
        run_traffic(150, 64'hFFFF_FFFF_FC00_0000);
        set_min_interval(MINI_W'(24000000));
        run_traffic(150, {$urandom, $urandom});
        set_min_interval(MINI_W'($urandom_range(2, 5000)));
        run_traffic(150, {$urandom, $urandom});
        set_min_interval(MIN_INTERVAL_RST);
        run_traffic(150, 64'hFFFF_FFFF_FFF0_0000);

        drain_results();
        if (errors == 0)
            $display("quiescent_checkin_tracker_unit: match");
        else
            $display("quiescent_checkin_tracker_unit: mismatch");
        $finish;
    end

endmodule

FILE: quiescent_checkin_tracker_unit.f
rtl/qct_pkg.sv
rtl/qct_if.sv
rtl/qct_eval.sv
rtl/qct_state.sv
rtl/quiescent_checkin_tracker_unit.sv
tb/quiescent_checkin_tracker_unit_tb.sv
